// File: hw/rtl/lspq_pkg.sv
// ----------------------------------------------------------------------------
// lspq_pkg
// Shared sizes, codes and control types of the linear-scan priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lspq_pkg;

   localparam int CAPACITY = 8;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int WORD_W   = 2 * DATA_W;

   // operation codes carried in the request tuser
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // status codes carried in the response tuser
   localparam logic [1:0] ST_STORED    = 2'd0;
   localparam logic [1:0] ST_REMOVED   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [1:0] ST_UNDERFLOW = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_APPEND,
      OP_OVERFLOW,
      OP_UNDERFLOW,
      OP_SCAN_INIT,
      OP_SCAN_READ,
      OP_SCAN_CMP,
      OP_SHIFT_INIT,
      OP_SHIFT_READ,
      OP_SHIFT_WRITE,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      logic   latch_req;
      logic   load_rsp;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic func_deq;
      logic full;
      logic empty;
      logic at_tail;
   } sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/linear_scan_priority_queue_unit.sv
// Enqueue, overflow and underflow: accept, S_DECODE, then S_RESP loads the response and raises rsp_tvalid.
// Dequeue of n entries with m moved down steps through decode, a read and a compare per entry,
// shift set-up, a read and a write per move, removal and response load.
// Throughput: one item at a time; the next is taken from the cycle after a response is loaded,
// and S_RESP holds for as long as the previous response still sits unaccepted.
// Reset (synchronous): empties the queue and sets order_mode to 0 (lowest priority first).
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_unit
// Priority queue over an insertion-ordered store with a linear minimum/maximum
// search and a shift-down on removal.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_scan_priority_queue_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration: bit 0 is order_mode
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] item_value, [63:32] item_priority
   input  wire logic [0:0]  req_tuser,   // [0] func
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [63:0] rsp_tdata,   // [31:0] out_value, [63:32] out_priority
   output logic      [1:0]  rsp_tuser    // [1:0] status
);
   import lspq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: walks each dequeue through scan and shift-down, one store access a step.
   lspq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: entry store, fill count, best-entry tracker and the output register.
   lspq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_func     (req_tuser[0]),
      .req_value    (req_tdata[DATA_W-1:0]),
      .req_priority (req_tdata[WORD_W-1:DATA_W]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_status   (rsp_tuser),
      .rsp_word     (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: hw/rtl/lspq_datapath.sv
// ----------------------------------------------------------------------------
// lspq_datapath
// Entry store, scan comparator, shift path, result and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data,
   input  wire logic                          req_func,
   input  wire logic [lspq_pkg::DATA_W-1:0]   req_value,
   input  wire logic [lspq_pkg::DATA_W-1:0]   req_priority,
   input  wire lspq_pkg::cmd_type             cmd,
   output lspq_pkg::sts_type                  sts,
   output logic      [1:0]                    rsp_status,
   output logic      [lspq_pkg::WORD_W-1:0]   rsp_word
);
   import lspq_pkg::*;

   logic [WORD_W-1:0] mem [CAPACITY];
   logic [WORD_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              mem_we;

   logic [CNT_W-1:0]  count_ff;
   logic              mode_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  next_idx;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [WORD_W-1:0] best_word_ff;
   logic              func_ff;
   logic [WORD_W-1:0] req_word_ff;
   logic [1:0]        res_status_ff;
   logic [WORD_W-1:0] res_word_ff;
   logic [1:0]        rsp_status_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              take;

   assign next_idx = idx_ff + CNT_W'(1);

   always_comb begin
      rd_addr = idx_ff[IDX_W-1:0];
      if (cmd.op == OP_SHIFT_READ) begin
         rd_addr = next_idx[IDX_W-1:0];
      end
   end

   always_comb begin
      mem_we  = 1'b0;
      wr_addr = idx_ff[IDX_W-1:0];
      wr_data = rd_data_ff;
      if (cmd.op == OP_APPEND) begin
         mem_we  = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = req_word_ff;
      end else if (cmd.op == OP_SHIFT_WRITE) begin
         mem_we = 1'b1;
      end
   end

   // strict improvement only, so ties keep the oldest entry
   always_comb begin
      if (mode_ff) begin
         take = $signed(best_word_ff[WORD_W-1:DATA_W]) < $signed(rd_data_ff[WORD_W-1:DATA_W]);
      end else begin
         take = $signed(rd_data_ff[WORD_W-1:DATA_W]) < $signed(best_word_ff[WORD_W-1:DATA_W]);
      end
      if (idx_ff == '0) begin
         take = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mode_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (cmd.op == OP_APPEND) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.op == OP_REMOVE) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         func_ff     <= req_func;
         req_word_ff <= {req_priority, req_value};
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_word_ff   <= res_word_ff;
      end
      case (cmd.op)
         OP_APPEND: begin
            res_status_ff <= ST_STORED;
            res_word_ff   <= '0;
         end
         OP_OVERFLOW: begin
            res_status_ff <= ST_OVERFLOW;
            res_word_ff   <= '0;
         end
         OP_UNDERFLOW: begin
            res_status_ff <= ST_UNDERFLOW;
            res_word_ff   <= '0;
         end
         OP_SCAN_INIT: begin
            idx_ff <= '0;
         end
         OP_SCAN_CMP: begin
            if (take) begin
               best_idx_ff  <= idx_ff[IDX_W-1:0];
               best_word_ff <= rd_data_ff;
            end
            idx_ff <= next_idx;
         end
         OP_SHIFT_INIT: begin
            idx_ff <= CNT_W'(best_idx_ff);
         end
         OP_SHIFT_WRITE: begin
            idx_ff <= next_idx;
         end
         OP_REMOVE: begin
            res_status_ff <= ST_REMOVED;
            res_word_ff   <= best_word_ff;
         end
         default: begin
         end
      endcase
   end

   assign sts.func_deq = (func_ff == FUNC_DEQ);
   assign sts.full     = (count_ff == CNT_W'(CAPACITY));
   assign sts.empty    = (count_ff == '0);
   assign sts.at_tail  = (next_idx == count_ff);

   assign rsp_status = rsp_status_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lspq_ctrl.sv
// ----------------------------------------------------------------------------
// lspq_ctrl
// Sequencer: accept, decode, scan, shift down, deliver the response item.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire lspq_pkg::sts_type sts,
   output lspq_pkg::cmd_type      cmd
);
   import lspq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_READ,
      S_SCAN_CMP,
      S_SHIFT_INIT,
      S_SHIFT_READ,
      S_SHIFT_WRITE,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cmd.latch_req = 1'b0;
      cmd.load_rsp  = 1'b0;
      cmd.op        = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!sts.func_deq) begin
               cmd.op   = sts.full ? OP_OVERFLOW : OP_APPEND;
               state_in = S_RESP;
            end else if (sts.empty) begin
               cmd.op   = OP_UNDERFLOW;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SCAN_READ;
            end
         end
         S_SCAN_READ: begin
            cmd.op   = OP_SCAN_READ;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.op   = OP_SCAN_CMP;
            state_in = sts.at_tail ? S_SHIFT_INIT : S_SCAN_READ;
         end
         S_SHIFT_INIT: begin
            cmd.op   = OP_SHIFT_INIT;
            state_in = S_SHIFT_READ;
         end
         S_SHIFT_READ: begin
            if (sts.at_tail) begin
               cmd.op   = OP_REMOVE;
               state_in = S_RESP;
            end else begin
               cmd.op   = OP_SHIFT_READ;
               state_in = S_SHIFT_WRITE;
            end
         end
         S_SHIFT_WRITE: begin
            cmd.op   = OP_SHIFT_WRITE;
            state_in = S_SHIFT_READ;
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lspq_checker.sv
// ----------------------------------------------------------------------------
// lspq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   import lspq_pkg::*;

   // a stalled response holds its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // only a removal carries a value and priority
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_REMOVED) |-> (rsp_tdata == '0))
      else $error("non-removal response with nonzero payload");

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one item at a time: an accepted item closes the request side next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on consecutive cycles");

endmodule

bind linear_scan_priority_queue_unit lspq_checker u_lspq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear-scan priority queue: stream items in,
// predict every response from a behavioural copy of the queue, compare each.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import lspq_pkg::*;

   localparam int CLK_HALF   = 6;
   localparam int SETTLE_CYC = 4 * CAPACITY + 8;
   localparam int HOLD_CYC   = 300;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] prio;
   } queue_rsp_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;
   logic [0:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // behavioural copy of the queue contents and removal order
   logic signed [DATA_W-1:0] held_value [CAPACITY];
   logic signed [DATA_W-1:0] held_prio  [CAPACITY];
   int   held_count = 0;
   logic order_desc = 1'b0;

   queue_rsp_type awaited_rsp [$];

   int errors         = 0;
   int n_enq          = 0;
   int n_deq          = 0;
   int n_overflow     = 0;
   int n_underflow    = 0;
   bit tx_idle_en     = 1'b1;
   bit rx_idle_en     = 1'b1;
   int rx_hold_cycles = 0;

   linear_scan_priority_queue_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   initial begin
      #(2 * CLK_HALF * 800_000);
      $display("FAIL");
      $finish;
   end

   // Apply one operation to the behavioural queue and return its response.
   function automatic queue_rsp_type queue_op_response(logic func, logic [31:0] val,
                                                       logic [31:0] prio);
      queue_rsp_type rsp;
      int            best;
      rsp = '0;
      if (func == FUNC_ENQ) begin
         n_enq++;
         if (held_count >= CAPACITY) begin
            rsp.status = ST_OVERFLOW;
            n_overflow++;
         end else begin
            held_value[held_count] = val;
            held_prio[held_count]  = prio;
            held_count++;
            rsp.status = ST_STORED;
         end
      end else begin
         n_deq++;
         if (held_count == 0) begin
            rsp.status = ST_UNDERFLOW;
            n_underflow++;
         end else begin
            // oldest entry wins ties: a later one must be strictly better
            best = 0;
            for (int k = 1; k < held_count; k++) begin
               if (order_desc ? (held_prio[k] > held_prio[best])
                              : (held_prio[k] < held_prio[best]))
                  best = k;
            end
            rsp.status = ST_REMOVED;
            rsp.value  = held_value[best];
            rsp.prio   = held_prio[best];
            for (int k = best; k + 1 < held_count; k++) begin
               held_value[k] = held_value[k + 1];
               held_prio[k]  = held_prio[k + 1];
            end
            held_count--;
         end
      end
      return rsp;
   endfunction

   // Mix of full-range words, small values (frequent ties) and corner words.
   function automatic logic [31:0] rand_word();
      logic [31:0] corner_words [4];
      corner_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 6) - 3;
         1:       return corner_words[$urandom_range(0, 3)];
         default: return $urandom();
      endcase
   endfunction

   // Offer one item; leave tvalid high so a back-to-back item needs no toggle.
   task automatic send_item(logic func, logic [31:0] val, logic [31:0] prio);
      int gap;
      gap = tx_idle_en ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {prio, val};
      do @(posedge clock); while (!req_tready);
      awaited_rsp.push_back(queue_op_response(func, val, prio));
   endtask

   // Drop the request and hold until every awaited response is in.
   task automatic wait_idle(int settle);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (awaited_rsp.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_order_mode(logic mode);
      wait_idle(4);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      order_desc = mode;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_op(int enq_pct);
      send_item(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                rand_word(), rand_word());
   endtask

   task automatic test_extremes_and_ties();
      write_order_mode(1'b0);
      send_item(FUNC_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // empty queue
      send_item(FUNC_ENQ, 32'h0000_0001, 32'd5);
      send_item(FUNC_ENQ, 32'h8000_0000, 32'h8000_0000);
      send_item(FUNC_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(FUNC_ENQ, 32'h0000_0002, 32'd5);
      send_item(FUNC_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(FUNC_ENQ, 32'h0000_0000, 32'h0000_0000);
      send_item(FUNC_ENQ, 32'h0000_0003, 32'h8000_0000);   // ties the minimum
      send_item(FUNC_ENQ, 32'hAAAA_5555, 32'd5);
      send_item(FUNC_ENQ, 32'h5555_AAAA, 32'd1);           // full queue
      repeat (4) send_item(FUNC_DEQ, 32'h0, 32'h0);
      write_order_mode(1'b1);
      repeat (5) send_item(FUNC_DEQ, 32'h0, 32'h0);        // ties on 5, then empty
      for (int k = 0; k < 3; k++)
         send_item(FUNC_ENQ, 32'h100 + k, 32'h7FFF_FFFF);
      repeat (3) send_item(FUNC_DEQ, 32'h0, 32'h0);
   endtask

   // Stall the response side for a long stretch while items keep coming.
   task automatic test_full_backpressure();
      wait_idle(4);
      tx_idle_en     = 1'b0;
      rx_hold_cycles = HOLD_CYC;
      repeat (30) send_random_op(67);
      wait_idle(4);
      tx_idle_en = 1'b1;
   endtask

   // Pause the request side until the queue has answered everything.
   task automatic test_sender_pause();
      repeat (12) send_random_op(60);
      wait_idle(SETTLE_CYC);
      repeat (12) send_random_op(40);
   endtask

   task automatic test_random_traffic(int n_items);
      int done;
      int per_phase;
      int enq_pct;
      done = 0;
      while (done < n_items) begin
         write_order_mode($urandom_range(0, 1));
         tx_idle_en = ($urandom_range(0, 3) != 0);
         rx_idle_en = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 2))
            0:       enq_pct = 25;
            1:       enq_pct = 75;
            default: enq_pct = 50;
         endcase
         per_phase = $urandom_range(60, 120);
         repeat (per_phase) send_random_op(enq_pct);
         done += per_phase;
      end
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
   endtask

   // Response side: random stalls per item, plus any hold-off that is asked for.
   initial begin : response_sink
      int wait_cyc;
      wait (!reset);
      @(posedge clock);
      forever begin
         wait_cyc = rx_hold_cycles + (rx_idle_en ? $urandom_range(0, 5) : 0);
         rx_hold_cycles = 0;
         if (wait_cyc > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cyc) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : response_check
      queue_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_rsp.size() == 0) begin
            $error("unexpected response: status %0d data %h", rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[31:0] !== want.value) begin
               $error("out_value: expected %h, actual %h", want.value, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.prio) begin
               $error("out_priority: expected %h, actual %h", want.prio, rsp_tdata[63:32]);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_extremes_and_ties();
      test_full_backpressure();
      test_sender_pause();
      test_random_traffic(1250);
      wait_idle(SETTLE_CYC);
      $display("Ran %0d enqueues (%0d on a full queue) and %0d dequeues (%0d on an empty one)",
               n_enq, n_overflow, n_deq, n_underflow);
      $display("in both removal orders, with random stalls and a long response hold-off.");
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/lspq_pkg.sv
hw/rtl/lspq_datapath.sv
hw/rtl/lspq_ctrl.sv
hw/rtl/linear_scan_priority_queue_unit.sv
hw/rtl/lspq_checker.sv
verif/testbench.sv
